// ===== src/wfrm_pkg.sv =====
// Shared constants for the windowed frame rate meter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package wfrm_pkg;

    localparam int HISTORY_DEPTH_DEF = 10;    // ring entries, window is one less
    localparam int TS_W              = 32;    // timestamp width
    localparam int SUM_W             = 36;    // window sum width, wraps
    localparam int FPS_W             = 14;    // result width
    localparam int FPS_MAX           = 16383; // saturation value of the result
    localparam int FPS_SCALE         = 1000;  // milliseconds per second
    localparam int QUEUE_DEPTH       = 2;     // jobs between front and back

endpackage

// ===== src/wfrm_front.sv =====
// Front end: takes frame beats, keeps the difference ring and the running
// window count and sum, and issues one division job per frame. Uses wfrm_pkg.
`timescale 1ns / 1ps

module wfrm_front #(
    parameter int HISTORY_DEPTH = wfrm_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic [wfrm_pkg::TS_W-1:0]                  i_timestamp_ms,
    output logic                                       o_push,
    output logic [$clog2(HISTORY_DEPTH)+wfrm_pkg::SUM_W-1:0] o_job,
    input  logic                                       i_full
);

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH);
    localparam int TS_W   = wfrm_pkg::TS_W;
    localparam int SUM_W  = wfrm_pkg::SUM_W;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_READ = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [TS_W-1:0]  r_prev;
    logic [TS_W-1:0]  r_diff;
    logic [TS_W-1:0]  r_rd;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] r_sum;
    logic             r_full;
    logic [TS_W-1:0]  r_ring [HISTORY_DEPTH];

    logic             accept;
    logic [SLOT_W-1:0] next_slot;
    logic [TS_W-1:0]  diff_w;
    logic             win_full;

    assign o_ready   = (r_state == F_IDLE);
    assign accept    = i_valid && o_ready;
    assign next_slot = (r_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : r_slot + 1'b1;
    assign diff_w    = i_timestamp_ms - r_prev;
    assign win_full  = (r_count == CNT_W'(HISTORY_DEPTH - 1));
    assign o_push    = (r_state == F_PUSH) && !i_full;
    assign o_job     = {r_count, r_sum};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:  if (accept) n_state = F_READ;
            F_READ:  n_state = F_PUSH;
            F_PUSH:  if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // Ring: write the new difference, read the oldest one (next slot).
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_slot] <= diff_w;
            r_rd           <= r_ring[next_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_diff <= diff_w;
            r_full <= win_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_prev  <= '0;
            r_slot  <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_prev <= i_timestamp_ms;
                r_slot <= next_slot;
            end
            if (r_state == F_READ) begin
                r_sum <= r_sum + SUM_W'(r_diff) - (r_full ? SUM_W'(r_rd) : '0);
                if (!r_full) r_count <= r_count + 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(HISTORY_DEPTH - 1))
        else $error("window count beyond depth");
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_W'(HISTORY_DEPTH - 1))
        else $error("write slot beyond ring");
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == F_READ)
        else $error("accepted beat did not start ring read");
    a_read_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == F_READ |=> r_state == F_PUSH && $stable(r_prev))
        else $error("sum update not followed by job push");
`endif

endmodule

// ===== src/wfrm_queue.sv =====
// Small register queue of division jobs between front and back.
// Uses wfrm_pkg for its depth.
`timescale 1ns / 1ps

module wfrm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = wfrm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            if (do_pop)  r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ===== src/wfrm_back.sv =====
// Back end: bit-serial restoring divider for 1000*count/sum with zero
// and saturation handling, and the output register. Uses wfrm_pkg.
`timescale 1ns / 1ps

module wfrm_back #(
    parameter int HISTORY_DEPTH = wfrm_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_q_valid,
    output logic                                       o_pop,
    input  logic [$clog2(HISTORY_DEPTH)+wfrm_pkg::SUM_W-1:0] i_job,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output logic [wfrm_pkg::FPS_W-1:0]                 o_fps
);

    localparam int CNT_W  = $clog2(HISTORY_DEPTH);
    localparam int SUM_W  = wfrm_pkg::SUM_W;
    localparam int FPS_W  = wfrm_pkg::FPS_W;
    localparam int NUM_W  = $clog2(wfrm_pkg::FPS_SCALE * (HISTORY_DEPTH - 1) + 1);
    localparam int STEP_W = $clog2(NUM_W);
    localparam int QX_W   = (NUM_W > FPS_W) ? NUM_W : FPS_W;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_DIV  = 2'd1;
    localparam logic [1:0] B_DONE = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [SUM_W-1:0]  r_div;
    logic [SUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;
    logic              r_zero;
    logic              r_out_valid;
    logic [FPS_W-1:0]  r_out;

    logic [CNT_W-1:0]  job_cnt;
    logic [SUM_W-1:0]  job_sum;
    logic [SUM_W:0]    trial;
    logic              q_bit;
    logic              out_free;
    logic [FPS_W-1:0]  result;

    assign job_cnt  = i_job[CNT_W+SUM_W-1:SUM_W];
    assign job_sum  = i_job[SUM_W-1:0];
    assign o_pop    = (r_state == B_IDLE) && i_q_valid;
    assign trial    = {r_rem, r_quo[NUM_W-1]};
    assign q_bit    = (trial >= {1'b0, r_div});
    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_fps    = r_out;

    always_comb begin
        if (r_zero) begin
            result = '0;
        end else if (QX_W'(r_quo) > QX_W'(wfrm_pkg::FPS_MAX)) begin
            result = FPS_W'(wfrm_pkg::FPS_MAX);
        end else begin
            result = FPS_W'(r_quo);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (i_q_valid) n_state = B_DIV;
            B_DIV:   if (r_step == STEP_W'(NUM_W - 1)) n_state = B_DONE;
            B_DONE:  if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // Divider datapath: dividend bits shift out of r_quo as quotient bits enter.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_div  <= job_sum;
            r_zero <= (job_sum == '0);
            r_quo  <= NUM_W'(job_cnt * wfrm_pkg::FPS_SCALE);
            r_rem  <= '0;
            r_step <= '0;
        end else if (r_state == B_DIV) begin
            r_rem  <= q_bit ? SUM_W'(trial - {1'b0, r_div}) : SUM_W'(trial);
            r_quo  <= {r_quo[NUM_W-2:0], q_bit};
            r_step <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == B_DONE) && out_free) r_out <= result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == B_DONE) && out_free) r_out_valid <= 1'b1;
            else if (i_ready)                    r_out_valid <= 1'b0;
        end
    end

endmodule

// ===== src/windowed_frame_rate_meter.sv =====
// Windowed frame rate meter: fps = floor(1000*count/sum) over the last
// HISTORY_DEPTH-1 frame intervals. A beat passes the front's read and push states,
// the job queue, the divider's NUM_W quotient bits (14 at the default depth) and
// the output register. The front takes new beats while the divider is busy.
// Reset (i_rst_n low, synchronous) clears the timestamp, window and job queue;
// the difference ring is not cleared, no entry's value is used before it is written.
`timescale 1ns / 1ps

module windowed_frame_rate_meter #(
    parameter int HISTORY_DEPTH = wfrm_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Frame event channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [wfrm_pkg::TS_W-1:0]   i_timestamp_ms,
    // Result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [wfrm_pkg::FPS_W-1:0]  o_frames_per_second
);

    // Job word: window count on top, 36-bit window sum below.
    localparam int JOB_W = $clog2(HISTORY_DEPTH) + wfrm_pkg::SUM_W;

    logic             front_push;
    logic [JOB_W-1:0] front_job;
    logic             q_full;
    logic             q_valid;
    logic             back_pop;
    logic [JOB_W-1:0] q_job;

    // Front: accepts a beat, forms the wrapping difference, updates the ring
    // (write new, read oldest), then updates count and sum and pushes a job.
    // It handles one beat at a time and only stalls when the queue is full.
    wfrm_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_timestamp_ms (i_timestamp_ms),
        .o_push         (front_push),
        .o_job          (front_job),
        .i_full         (q_full)
    );

    // Two-entry job queue decouples front and divider stalls.
    wfrm_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (back_pop),
        .o_data  (q_job)
    );

    // Back: one quotient bit per cycle, zero-sum and saturation at the end,
    // result held in the output register until taken.
    wfrm_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_pop     (back_pop),
        .i_job     (q_job),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_fps     (o_frames_per_second)
    );

endmodule
